// ===== rtl/core/mpenc_pkg.sv =====
package mpenc_pkg;

    // Default width of the write position counter.
    localparam int POSITION_BITS_DEF = 24;

    // Field widths fixed by the interface.
    localparam int FUNC_BITS   = 4;
    localparam int VALUE_BITS  = 64;
    localparam int CAP_BITS    = 24;
    localparam int DEPTH_BITS  = 16;
    localparam int COUNT_BITS  = 24;
    localparam int STATUS_BITS = 2;

    // At most one type byte and eight payload bytes per word.
    localparam int MAX_BYTES  = 9;
    localparam int NBYTE_BITS = 4;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_NIL       = 4'd0,
        FN_FALSE     = 4'd1,
        FN_TRUE      = 4'd2,
        FN_UINT      = 4'd3,
        FN_SINT      = 4'd4,
        FN_FLOAT     = 4'd5,
        FN_MAP_BEGIN = 4'd6,
        FN_MAP_END   = 4'd7,
        FN_ARR_BEGIN = 4'd8,
        FN_ARR_END   = 4'd9,
        FN_STR_HDR   = 4'd10,
        FN_STR_BYTE  = 4'd11,
        FN_RESTART   = 4'd12
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // MessagePack type bytes.
    localparam logic [7:0] TAG_NIL    = 8'hC0;
    localparam logic [7:0] TAG_FALSE  = 8'hC2;
    localparam logic [7:0] TAG_TRUE   = 8'hC3;
    localparam logic [7:0] TAG_F64    = 8'hCB;
    localparam logic [7:0] TAG_U8     = 8'hCC;
    localparam logic [7:0] TAG_U16    = 8'hCD;
    localparam logic [7:0] TAG_U32    = 8'hCE;
    localparam logic [7:0] TAG_U64    = 8'hCF;
    localparam logic [7:0] TAG_I8     = 8'hD0;
    localparam logic [7:0] TAG_I16    = 8'hD1;
    localparam logic [7:0] TAG_I32    = 8'hD2;
    localparam logic [7:0] TAG_I64    = 8'hD3;
    localparam logic [7:0] TAG_STR16  = 8'hDA;
    localparam logic [7:0] TAG_ARR16  = 8'hDC;
    localparam logic [7:0] TAG_MAP16  = 8'hDE;
    localparam logic [7:0] TAG_FIXMAP = 8'h80;
    localparam logic [7:0] TAG_FIXARR = 8'h90;
    localparam logic [7:0] TAG_FIXSTR = 8'hA0;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = 16'hFFFF;

endpackage

// ===== rtl/core/messagepack_value_encoder.sv =====
// Channel   Dir  Group   Contents
// -------   ---  ------  ------------------------------------------------------------
// input     in   s_axis  tuser[3:0] func, tdata[63:0] value
// output    out  m_axis  tdata: out_byte, map_depth, array_depth, bytes_written;
//                        tuser: byte_valid, status; tlast marks the final word of an item
// config    in   i_cfg   i_cfg_we / i_cfg_wdata[23:0] buffer_size
//
// Each input word is decoded in the cycle it is accepted, and its whole byte plan is
// stored in the output register. An item yields one word per byte written, plus a status
// word if it fails or writes nothing: one for string bytes, depth ends and errors that
// write nothing, two for a type byte with a cut payload, up to nine for a 64-bit value.
// The output register drains one word per cycle; the next input word is taken in the
// cycle the final word of the current item leaves, so single-word items flow every cycle.
// Reset (i_rst_n low at a clock edge) clears the position, depths, pending string,
// capacity and the output register. A stall on m_axis holds the current word.
module messagepack_value_encoder #(
    parameter int POSITION_BITS = mpenc_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,    // buffer_size

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [3:0]  s_axis_tuser,   // [3:0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [23:8] map_depth, [39:24] array_depth, [63:40] bytes_written
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic        m_axis_tlast
);

    // Width that holds both the capacity and the position.
    localparam int CW = (POSITION_BITS > mpenc_pkg::CAP_BITS) ?
                        POSITION_BITS : mpenc_pkg::CAP_BITS;
    // Signed room arithmetic: room can go negative when the capacity is lowered,
    // and the largest request is a string header plus a 65535 byte payload.
    localparam int RW = CW + 2;
    localparam logic [CW-1:0] CAP_LIM = CW'((64'd1 << POSITION_BITS) - 64'd1);
    localparam int PLAN_BITS = 8 * mpenc_pkg::MAX_BYTES;
    localparam int NB = mpenc_pkg::NBYTE_BITS;
    localparam int DB = mpenc_pkg::DEPTH_BITS;

    // Encoder state.
    logic [CW-1:0]            r_cap;
    logic [POSITION_BITS-1:0] r_pos;
    logic [DB-1:0]            r_map;
    logic [DB-1:0]            r_arr;
    logic [DB-1:0]            r_left;
    logic                     r_drop;

    logic [CW-1:0]            n_cap;
    logic [POSITION_BITS-1:0] n_pos;
    logic [DB-1:0]            n_map;
    logic [DB-1:0]            n_arr;
    logic [DB-1:0]            n_left;
    logic                     n_drop;

    // Output register: the byte plan of the item being delivered.
    logic                     r_valid;
    logic [PLAN_BITS-1:0]     r_bytes;
    logic [NB-1:0]            r_nbytes;
    logic                     r_extra;
    mpenc_pkg::t_status       r_status;
    logic [POSITION_BITS-1:0] r_base;

    // Decode of the incoming word.
    mpenc_pkg::t_func         func;
    logic [63:0]              value;
    logic [7:0]               tag;
    logic [NB-1:0]            pay;
    logic                     writes;
    logic                     str_hdr;
    logic                     restart;
    mpenc_pkg::t_status       pre_st;
    mpenc_pkg::t_status       st;
    logic [NB-1:0]            nwr;
    logic [63:0]              pay_word;
    logic [PLAN_BITS-1:0]     plan;

    logic signed [RW-1:0]     room;
    logic signed [RW-1:0]     need_b;
    logic signed [RW-1:0]     need_s;
    logic                     fit_a;
    logic                     fit_b;
    logic                     fit_s;
    logic                     hdr_ok;

    logic                     in_acc;
    logic                     out_take;
    logic                     out_last;
    logic                     out_is_byte;
    logic [POSITION_BITS-1:0] out_pos;
    logic [CW-1:0]            out_pos_ext;
    logic [CW-1:0]            cfg_ext;

    assign func  = mpenc_pkg::t_func'(s_axis_tuser);
    assign value = s_axis_tdata;

    // Usable capacity is clipped to what the position counter can reach.
    assign cfg_ext = CW'(i_cfg_wdata);
    assign n_cap   = (cfg_ext < CAP_LIM) ? cfg_ext : CAP_LIM;

    // Pick the type byte and payload length for this word.
    always_comb begin
        tag     = 8'h00;
        pay     = '0;
        writes  = 1'b0;
        str_hdr = 1'b0;
        restart = 1'b0;
        pre_st  = mpenc_pkg::ST_OK;
        n_map   = r_map;
        n_arr   = r_arr;
        unique case (func)
            mpenc_pkg::FN_NIL: begin
                tag    = mpenc_pkg::TAG_NIL;
                writes = 1'b1;
            end
            mpenc_pkg::FN_FALSE: begin
                tag    = mpenc_pkg::TAG_FALSE;
                writes = 1'b1;
            end
            mpenc_pkg::FN_TRUE: begin
                tag    = mpenc_pkg::TAG_TRUE;
                writes = 1'b1;
            end
            mpenc_pkg::FN_UINT: begin
                writes = 1'b1;
                if (value[63:7] == '0) begin
                    tag = value[7:0];
                end else if (value[63:8] == '0) begin
                    tag = mpenc_pkg::TAG_U8;
                    pay = NB'(1);
                end else if (value[63:16] == '0) begin
                    tag = mpenc_pkg::TAG_U16;
                    pay = NB'(2);
                end else if (value[63:32] == '0) begin
                    tag = mpenc_pkg::TAG_U32;
                    pay = NB'(4);
                end else begin
                    tag = mpenc_pkg::TAG_U64;
                    pay = NB'(8);
                end
            end
            mpenc_pkg::FN_SINT: begin
                writes = 1'b1;
                // Positive fixint covers 0..127, negative fixint -32..-1.
                if ((value[63:7] == '0) || (&value[63:5])) begin
                    tag = value[7:0];
                end else if ((value[63:7] == '0) || (&value[63:7])) begin
                    tag = mpenc_pkg::TAG_I8;
                    pay = NB'(1);
                end else if ((value[63:15] == '0) || (&value[63:15])) begin
                    tag = mpenc_pkg::TAG_I16;
                    pay = NB'(2);
                end else if ((value[63:31] == '0) || (&value[63:31])) begin
                    tag = mpenc_pkg::TAG_I32;
                    pay = NB'(4);
                end else begin
                    tag = mpenc_pkg::TAG_I64;
                    pay = NB'(8);
                end
            end
            mpenc_pkg::FN_FLOAT: begin
                tag    = mpenc_pkg::TAG_F64;
                pay    = NB'(8);
                writes = 1'b1;
            end
            mpenc_pkg::FN_MAP_BEGIN, mpenc_pkg::FN_ARR_BEGIN: begin
                if (value[63:16] != '0) begin
                    pre_st = mpenc_pkg::ST_RANGE;
                end else begin
                    writes = 1'b1;
                    if (value[15:4] == '0) begin
                        tag = ((func == mpenc_pkg::FN_MAP_BEGIN) ?
                               mpenc_pkg::TAG_FIXMAP : mpenc_pkg::TAG_FIXARR)
                              | {4'h0, value[3:0]};
                    end else begin
                        tag = (func == mpenc_pkg::FN_MAP_BEGIN) ?
                              mpenc_pkg::TAG_MAP16 : mpenc_pkg::TAG_ARR16;
                        pay = NB'(2);
                    end
                    // The depth counts up even when the header does not fit.
                    if (func == mpenc_pkg::FN_MAP_BEGIN) begin
                        if (r_map != mpenc_pkg::DEPTH_MAX) begin
                            n_map = r_map + DB'(1);
                        end
                    end else begin
                        if (r_arr != mpenc_pkg::DEPTH_MAX) begin
                            n_arr = r_arr + DB'(1);
                        end
                    end
                end
            end
            mpenc_pkg::FN_MAP_END: begin
                if (r_map == '0) begin
                    pre_st = mpenc_pkg::ST_UNDERFLOW;
                end else begin
                    n_map = r_map - DB'(1);
                end
            end
            mpenc_pkg::FN_ARR_END: begin
                if (r_arr == '0) begin
                    pre_st = mpenc_pkg::ST_UNDERFLOW;
                end else begin
                    n_arr = r_arr - DB'(1);
                end
            end
            mpenc_pkg::FN_STR_HDR: begin
                if (value[63:16] != '0) begin
                    pre_st = mpenc_pkg::ST_RANGE;
                end else begin
                    writes  = 1'b1;
                    str_hdr = 1'b1;
                    if (value[15:5] == '0) begin
                        tag = mpenc_pkg::TAG_FIXSTR | {3'b000, value[4:0]};
                    end else begin
                        tag = mpenc_pkg::TAG_STR16;
                        pay = NB'(2);
                    end
                end
            end
            mpenc_pkg::FN_STR_BYTE: begin
                if (r_left == '0) begin
                    pre_st = mpenc_pkg::ST_RANGE;
                end else if (r_drop) begin
                    pre_st = mpenc_pkg::ST_FULL;
                end else begin
                    tag    = value[7:0];
                    writes = 1'b1;
                end
            end
            mpenc_pkg::FN_RESTART: begin
                restart = 1'b1;
                n_map   = '0;
                n_arr   = '0;
            end
            default: begin
                // Unused codes are ignored.
            end
        endcase
    end

    // Room left in the buffer, and the three part checks.
    assign room   = $signed(RW'(r_cap)) - $signed(RW'(r_pos));
    assign need_b = $signed(RW'(pay) + RW'(1));
    assign need_s = $signed(RW'(pay) + RW'(value[15:0]) + RW'(1));
    assign fit_a  = room >= $signed(RW'(1));
    assign fit_b  = room >= need_b;
    assign fit_s  = room >= need_s;

    // Parts are all-or-nothing: the type byte first, then the payload word.
    always_comb begin
        st     = pre_st;
        nwr    = '0;
        hdr_ok = 1'b0;
        n_left = r_left;
        n_drop = r_drop;
        if (writes) begin
            if (!fit_a) begin
                st = mpenc_pkg::ST_FULL;
            end else if ((pay != '0) && !fit_b) begin
                nwr = NB'(1);
                st  = mpenc_pkg::ST_FULL;
            end else begin
                nwr    = pay + NB'(1);
                hdr_ok = 1'b1;
            end
        end
        if (func == mpenc_pkg::FN_STR_HDR) begin
            n_left = '0;
            n_drop = 1'b0;
            if (str_hdr) begin
                // The whole string payload has to fit behind its header.
                if (hdr_ok && !fit_s) begin
                    st = mpenc_pkg::ST_FULL;
                end
                n_left = value[15:0];
                n_drop = !(hdr_ok && fit_s) && (value[15:0] != '0);
            end
        end else if ((func == mpenc_pkg::FN_STR_BYTE) && (r_left != '0)) begin
            n_left = r_left - DB'(1);
            if (r_left == DB'(1)) begin
                n_drop = 1'b0;
            end
        end else if (restart) begin
            n_left = '0;
            n_drop = 1'b0;
        end
    end

    // Payload bytes are placed big-endian right behind the type byte.
    always_comb begin
        unique case (pay)
            NB'(1):  pay_word = {value[7:0], 56'h0};
            NB'(2):  pay_word = {value[15:0], 48'h0};
            NB'(4):  pay_word = {value[31:0], 32'h0};
            NB'(8):  pay_word = value;
            default: pay_word = 64'h0;
        endcase
    end

    assign plan  = {tag, pay_word};
    assign n_pos = restart ? '0 : (r_pos + POSITION_BITS'(nwr));

    // Output side. A byte word is pending while r_nbytes is nonzero; after the
    // bytes comes one status word when the item failed or wrote nothing.
    assign out_is_byte = (r_nbytes != '0);
    assign out_last    = (r_nbytes == '0) || ((r_nbytes == NB'(1)) && !r_extra);
    assign out_take    = r_valid && m_axis_tready;
    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_valid || (m_axis_tready && out_last);

    assign out_pos     = out_is_byte ? (r_base + POSITION_BITS'(1)) : r_base;
    assign out_pos_ext = CW'(out_pos);

    // Depths only change when a new item is accepted, and that happens at the
    // edge the current item's final word leaves, so the state registers always
    // hold the depths after the item being delivered.
    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {out_pos_ext[mpenc_pkg::COUNT_BITS-1:0], r_arr, r_map,
                            out_is_byte ? r_bytes[PLAN_BITS-1 -: 8] : 8'h00};
    assign m_axis_tuser  = {out_is_byte ? mpenc_pkg::ST_OK : r_status, out_is_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= '0;
            r_pos    <= '0;
            r_map    <= '0;
            r_arr    <= '0;
            r_left   <= '0;
            r_drop   <= 1'b0;
            r_valid  <= 1'b0;
            r_nbytes <= '0;
            r_extra  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            if (in_acc) begin
                r_pos    <= n_pos;
                r_map    <= n_map;
                r_arr    <= n_arr;
                r_left   <= n_left;
                r_drop   <= n_drop;
                r_valid  <= 1'b1;
                r_nbytes <= nwr;
                r_extra  <= (st != mpenc_pkg::ST_OK) || (nwr == '0);
            end else if (out_take) begin
                if (out_last) begin
                    r_valid <= 1'b0;
                end else begin
                    r_nbytes <= r_nbytes - NB'(1);
                end
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bytes  <= plan;
            r_status <= st;
            r_base   <= restart ? '0 : r_pos;
        end else if (out_take && !out_last && out_is_byte) begin
            r_bytes <= {r_bytes[PLAN_BITS-9:0], 8'h00};
            r_base  <= r_base + POSITION_BITS'(1);
        end
    end

endmodule

// ===== bench/tb_messagepack_value_encoder.sv =====
module tb_messagepack_value_encoder;
    import mpenc_pkg::*;

    localparam int POS_BITS = POSITION_BITS_DEF;
    localparam longint unsigned POS_LIMIT = (64'd1 << POS_BITS) - 1;
    localparam int SHOW_LIMIT = 30;
    localparam int IDLE_PAUSE = 12;
    localparam longint RUN_LIMIT = 64'd8_000_000;

    // Function codes that the block decodes as nothing.
    localparam logic [3:0] FN_UNUSED_LO = 4'd13;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    messagepack_value_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // One value to encode, as it travels on the input stream.
    typedef struct {
        logic [3:0]  func;
        logic [63:0] value;
    } value_word_t;

    // One output word as the encoder should present it.
    typedef struct {
        logic [7:0]  data;
        logic        written;
        logic        tail;
        t_status     status;
        logic [15:0] maps;
        logic [15:0] arrays;
        logic [23:0] pos;
    } enc_word_t;

    value_word_t values_to_send[$];
    enc_word_t   encoded_words[$];
    enc_word_t   item_words[$];

    // Shadow of the encoder: capacity register, write position, depths and
    // the string that is waiting for its bytes.
    logic [23:0]     cap_m = '0;
    longint unsigned pos_m = 0;
    int unsigned     open_maps = 0;
    int unsigned     open_arrays = 0;
    int unsigned     str_left = 0;
    bit              str_drop = 1'b0;

    int  pushed_count = 0;
    int  ignored_count = 0;
    int  accepted_count = 0;
    int  words_seen = 0;
    int  errors = 0;
    int  sizes_used = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;
    bit  value_taken = 1'b0;

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Encoding shadow
    // ------------------------------------------------------------------

    function automatic longint unsigned usable_cap();
        longint unsigned c;
        c = cap_m;
        return (c < POS_LIMIT) ? c : POS_LIMIT;
    endfunction

    function automatic bit fits(longint unsigned n);
        return pos_m + n <= usable_cap();
    endfunction

    function automatic void add_word(logic [7:0] b, logic ok, t_status st);
        enc_word_t w;
        w.data = b;
        w.written = ok;
        w.tail = 1'b0;
        w.status = st;
        w.maps = '0;
        w.arrays = '0;
        w.pos = pos_m[23:0];
        item_words.push_back(w);
    endfunction

    // A part (type byte, length word or payload) is written whole or not at all.
    function automatic bit put_part(logic [63:0] v, int n);
        if (!fits(n))
            return 1'b0;
        for (int i = n; i > 0; i--) begin
            pos_m++;
            add_word(v[8*(i-1) +: 8], 1'b1, ST_OK);
        end
        return 1'b1;
    endfunction

    function automatic t_status put_byte(logic [7:0] b);
        return put_part({56'd0, b}, 1) ? ST_OK : ST_FULL;
    endfunction

    // Type byte and then the payload; once the type byte is in, a payload that
    // does not fit still ends the item with buffer full.
    function automatic t_status put_tagged(logic [7:0] tag, logic [63:0] v, int n);
        if (!put_part({56'd0, tag}, 1))
            return ST_FULL;
        if (n > 0 && !put_part(v, n))
            return ST_FULL;
        return ST_OK;
    endfunction

    function automatic t_status encode_uint(logic [63:0] v);
        if (v <= 64'h7F)
            return put_byte(v[7:0]);
        if (v <= 64'hFF)
            return put_tagged(TAG_U8, v, 1);
        if (v <= 64'hFFFF)
            return put_tagged(TAG_U16, v, 2);
        if (v <= 64'hFFFF_FFFF)
            return put_tagged(TAG_U32, v, 4);
        return put_tagged(TAG_U64, v, 8);
    endfunction

    // Range tests by offset so that negative values fold into one compare.
    function automatic t_status encode_sint(logic [63:0] v);
        logic [63:0] b;
        b = v + 64'd32;
        if (b < 64'd160)
            return put_byte(v[7:0]);
        b = v + 64'h80;
        if (b < 64'h100)
            return put_tagged(TAG_I8, v, 1);
        b = v + 64'h8000;
        if (b < 64'h1_0000)
            return put_tagged(TAG_I16, v, 2);
        b = v + 64'h8000_0000;
        if (b < 64'h1_0000_0000)
            return put_tagged(TAG_I32, v, 4);
        return put_tagged(TAG_I64, v, 8);
    endfunction

    function automatic t_status open_container(bit is_map, logic [63:0] count);
        t_status st;
        if (count >= 64'd65536)
            return ST_RANGE;
        if (count <= 64'd15)
            st = put_byte((is_map ? TAG_FIXMAP : TAG_FIXARR) | count[7:0]);
        else
            st = put_tagged(is_map ? TAG_MAP16 : TAG_ARR16, count, 2);
        // The depth goes up even when the header was lost to a full buffer.
        if (is_map) begin
            if (open_maps < DEPTH_MAX)
                open_maps++;
        end else begin
            if (open_arrays < DEPTH_MAX)
                open_arrays++;
        end
        return st;
    endfunction

    function automatic t_status close_container(bit is_map);
        if (is_map) begin
            if (open_maps == 0)
                return ST_UNDERFLOW;
            open_maps--;
        end else begin
            if (open_arrays == 0)
                return ST_UNDERFLOW;
            open_arrays--;
        end
        return ST_OK;
    endfunction

    // The header also reserves the whole payload: if it would not fit, the
    // header reports buffer full and the bytes that follow are discarded.
    function automatic t_status open_string(logic [63:0] len);
        bit ok;
        str_left = 0;
        str_drop = 1'b0;
        if (len >= 64'd65536)
            return ST_RANGE;
        if (len <= 64'd31)
            ok = put_part({56'd0, TAG_FIXSTR | len[7:0]}, 1);
        else
            ok = (put_tagged(TAG_STR16, len, 2) == ST_OK);
        if (ok && !fits(len))
            ok = 1'b0;
        str_left = len[15:0];
        str_drop = !ok && (len != 0);
        return ok ? ST_OK : ST_FULL;
    endfunction

    function automatic t_status string_byte(logic [7:0] b);
        t_status st;
        st = ST_OK;
        if (str_left == 0)
            return ST_RANGE;
        str_left--;
        if (str_drop)
            st = ST_FULL;
        else if (!put_part({56'd0, b}, 1))
            st = ST_FULL;
        if (str_left == 0)
            str_drop = 1'b0;
        return st;
    endfunction

    // Works out every output word that one accepted value causes and queues
    // them behind the words still outstanding.
    function automatic void encode_value(logic [3:0] fn, logic [63:0] v);
        t_status st;
        st = ST_OK;
        item_words.delete();
        case (fn)
            FN_NIL:       st = put_byte(TAG_NIL);
            FN_FALSE:     st = put_byte(TAG_FALSE);
            FN_TRUE:      st = put_byte(TAG_TRUE);
            FN_UINT:      st = encode_uint(v);
            FN_SINT:      st = encode_sint(v);
            FN_FLOAT:     st = put_tagged(TAG_F64, v, 8);
            FN_MAP_BEGIN: st = open_container(1'b1, v);
            FN_MAP_END:   st = close_container(1'b1);
            FN_ARR_BEGIN: st = open_container(1'b0, v);
            FN_ARR_END:   st = close_container(1'b0);
            FN_STR_HDR:   st = open_string(v);
            FN_STR_BYTE:  st = string_byte(v[7:0]);
            FN_RESTART: begin
                pos_m = 0;
                open_maps = 0;
                open_arrays = 0;
                str_left = 0;
                str_drop = 1'b0;
            end
            default: ;
        endcase
        if (st != ST_OK || item_words.size() == 0)
            add_word(8'h00, 1'b0, st);
        foreach (item_words[k]) begin
            item_words[k].maps = open_maps[15:0];
            item_words[k].arrays = open_arrays[15:0];
            item_words[k].tail = (k == item_words.size() - 1);
            encoded_words.push_back(item_words[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_value(logic [3:0] fn, logic [63:0] v);
        value_word_t w;
        w.func = fn;
        w.value = v;
        values_to_send.push_back(w);
        pushed_count++;
        if (fn > FN_RESTART)
            ignored_count++;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Unsigned values spread over every encoding width.
    function automatic logic [63:0] rand_uint();
        int k;
        logic [63:0] v;
        k = $urandom_range(0, 8);
        v = rand64();
        if (k < 8)
            v &= ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * k));
        return v;
    endfunction

    // Signed values sign-extended from a random width, so both fixint ends
    // and every tagged width turn up.
    function automatic logic [63:0] rand_sint();
        int w;
        logic [63:0] t;
        case ($urandom_range(0, 4))
            0: w = 6;
            1: w = 8;
            2: w = 16;
            3: w = 32;
            default: w = 64;
        endcase
        t = rand64() << (64 - w);
        return $signed(t) >>> (64 - w);
    endfunction

    function automatic logic [63:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 20);
        if (r < 88)
            return $urandom_range(16, 65535);
        if (r < 94)
            return $urandom_range(65535, 65536);
        return rand64();
    endfunction

    function automatic void queue_scalar();
        case ($urandom_range(0, 5))
            0:       queue_value(4'($urandom_range(FN_NIL, FN_TRUE)), rand64());
            1, 2:    queue_value(FN_UINT, rand_uint());
            3, 4:    queue_value(FN_SINT, rand_sint());
            default: queue_value(FN_FLOAT, rand64());
        endcase
    endfunction

    // Mostly well-formed pieces of a document (scalars, containers closed
    // again, strings followed by their bytes), the rest stray or broken words.
    function automatic void queue_random_value();
        int r;
        int n;
        bit is_map;
        r = $urandom_range(0, 99);
        is_map = $urandom_range(0, 1);
        if (r < 40) begin
            queue_scalar();
        end else if (r < 58) begin
            queue_value(is_map ? FN_MAP_BEGIN : FN_ARR_BEGIN, rand_count());
            n = $urandom_range(0, 3);
            repeat (n) queue_scalar();
            if ($urandom_range(0, 99) < 85)
                queue_value(is_map ? FN_MAP_END : FN_ARR_END, rand64());
        end else if (r < 80) begin
            n = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 12) : $urandom_range(28, 40);
            queue_value(FN_STR_HDR, n);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < 6)
                    queue_scalar();
                queue_value(FN_STR_BYTE, rand64());
            end
        end else begin
            case ($urandom_range(0, 6))
                0: queue_value(FN_MAP_END, rand64());
                1: queue_value(FN_ARR_END, rand64());
                2: queue_value(FN_STR_BYTE, rand64());
                3: queue_value(FN_RESTART, rand64());
                4: queue_value(4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)), rand64());
                5: queue_value(FN_STR_HDR, $urandom_range(0, 1) ? rand64()
                                                                : 64'($urandom_range(0, 65536)));
                default: queue_value(is_map ? FN_MAP_BEGIN : FN_ARR_BEGIN,
                                     $urandom_range(0, 1) ? rand64() : 64'd65536);
            endcase
        end
    endfunction

    // The capacity only changes while nothing is in flight.
    task automatic set_capacity(logic [23:0] cap);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cap_m = cap;
        sizes_used++;
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (accepted_count != pushed_count || encoded_words.size() != 0);
        repeat (IDLE_PAUSE) @(negedge i_clk);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t  %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued values at the falling edge, holding each word
    // until it has been taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feed_values
        value_word_t nxt;
        if (i_rst_n && !(s_axis_tvalid && !value_taken)) begin
            if (s_axis_tvalid && !no_idle)
                send_gap = pick_gap();
            if (send_gap > 0 || values_to_send.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end else begin
                nxt = values_to_send.pop_front();
                s_axis_tuser <= nxt.func;
                s_axis_tdata <= nxt.value;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Receiver back-pressure, with random stalls of mixed length.
    always @(negedge i_clk) begin : drain_words
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    // Monitor: checks each output word against the oldest expectation and
    // feeds every accepted input word to the shadow encoder.
    always @(posedge i_clk) begin : watch_ports
        enc_word_t want;
        if (i_rst_n) begin
            value_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen++;
                if (encoded_words.size() == 0) begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t  unexpected word: expected none, got tdata 0x%0h tuser 0x%0h",
                                 $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = encoded_words.pop_front();
                    check_field("out_byte", want.data, m_axis_tdata[7:0]);
                    check_field("map_depth", want.maps, m_axis_tdata[23:8]);
                    check_field("array_depth", want.arrays, m_axis_tdata[39:24]);
                    check_field("bytes_written", want.pos, m_axis_tdata[63:40]);
                    check_field("byte_valid", want.written, m_axis_tuser[0]);
                    check_field("status", want.status, m_axis_tuser[2:1]);
                    check_field("tlast", want.tail, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_count++;
                encode_value(s_axis_tuser, s_axis_tdata);
            end
        end else begin
            value_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_phases
        int target;
        logic [23:0] cap;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // No room at all: headers are lost, the depth still goes up, and a
        // string that cannot be written discards its bytes.
        set_capacity(24'd0);
        queue_value(FN_MAP_BEGIN, 64'd2);
        queue_value(FN_STR_HDR, 64'd3);
        queue_value(FN_STR_BYTE, 64'h5A);
        queue_value(FN_MAP_END, 64'd0);
        queue_value(FN_MAP_END, 64'd0);
        wait_idle();

        // Full capacity: fixint edges, several tagged widths, range errors,
        // underflow, a stray string byte, an unused code and a restart.
        set_capacity(24'hFF_FFFF);
        queue_value(FN_NIL, 64'd0);
        queue_value(FN_FALSE, 64'd0);
        queue_value(FN_TRUE, 64'd0);
        queue_value(FN_UINT, 64'h7F);
        queue_value(FN_UINT, 64'h80);
        queue_value(FN_UINT, 64'h1_0000);
        queue_value(FN_UINT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_value(FN_SINT, -64'sd32);
        queue_value(FN_SINT, -64'sd33);
        queue_value(FN_SINT, 64'd128);
        queue_value(FN_SINT, 64'h8000_0000_0000_0000);
        queue_value(FN_FLOAT, 64'h4009_21FB_5444_2D18);
        queue_value(FN_MAP_BEGIN, 64'd16);
        queue_value(FN_MAP_BEGIN, 64'd65536);
        queue_value(FN_ARR_BEGIN, 64'd15);
        queue_value(FN_ARR_END, 64'd0);
        queue_value(FN_ARR_END, 64'd0);
        queue_value(FN_STR_HDR, 64'd70000);
        queue_value(FN_STR_BYTE, 64'hFF);
        queue_value(FN_UNUSED_LO, 64'd0);
        queue_value(FN_RESTART, 64'd0);
        wait_idle();

        // Capacity dropped to a tiny buffer while the position is not zero:
        // a float whose payload is cut off, a string byte that no longer
        // fits, and a string header that cannot be written at all.
        queue_value(FN_UINT, 64'h1234);
        wait_idle();
        set_capacity(24'd6);
        queue_value(FN_NIL, 64'd0);
        queue_value(FN_RESTART, 64'd0);
        queue_value(FN_STR_HDR, 64'd2);
        queue_value(FN_UINT, 64'h1234);
        queue_value(FN_FLOAT, 64'hC000_0000_0000_0000);
        queue_value(FN_STR_BYTE, 64'h41);
        queue_value(FN_STR_BYTE, 64'h42);
        queue_value(FN_STR_HDR, 64'd3);
        queue_value(FN_STR_BYTE, 64'h43);
        wait_idle();

        // Random documents under a small, a medium, the largest and a random
        // capacity; the third phase runs without any idling.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       cap = $urandom_range(8, 64);
                1:       cap = $urandom_range(200, 3000);
                2:       cap = 24'hFF_FFFF;
                default: cap = $urandom_range(0, 24'hFF_FFFF);
            endcase
            no_idle = (p == 2);
            set_capacity(cap);
            queue_value(FN_RESTART, 64'd0);
            target = pushed_count - ignored_count + 60;
            while (pushed_count - ignored_count < target)
                queue_random_value();
            wait_idle();
        end

        $display("Encoded %0d values into %0d checked words under %0d buffer sizes.",
                 accepted_count, words_seen, sizes_used);
        $display("Covered every value kind, buffer overflow, range errors and underflow.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Timeout with %0d words still expected", encoded_words.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
